/* hdl/soe_pkg.sv */
// Shared types and constants for the spiral order emitter.
// Used by the front, queue, back and top-level modules; no dependencies.
package soe_pkg;

   localparam int ELEM_W      = 8;
   localparam int DIM_W       = 4;
   localparam int LOAD_W      = 7;
   localparam int CSR_IDX_W   = 4;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = 1;
   localparam int QCOUNT_W    = 2;

   localparam logic [DIM_W-1:0]     DIM_RESET     = 4'd8;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT = 4'd1;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic             bank;
   } job_type;

endpackage

/* hdl/soe_front.sv */
// Front end: configuration registers, load counter and matrix completion.
// Writes elements into the bank being filled and queues a job per matrix; uses soe_pkg.
module soe_front
   import soe_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 8
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_stall,
   input  logic [ELEM_W-1:0]                                req_element_value,
   input  logic                                             csr_valid,
   output logic                                             csr_ready,
   input  logic [CSR_IDX_W-1:0]                             csr_index,
   input  logic [DIM_W-1:0]                                 csr_wdata,
   output logic                                             wr_en,
   output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1):0] wr_addr,
   output logic [DATA_WIDTH-1:0]                            wr_data,
   output logic                                             push,
   output job_type                                          push_job,
   input  logic                                             job_done
);

   localparam int ADDR_W = (MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;

   logic [DIM_W-1:0]  row_count_ff, row_count_in;
   logic [DIM_W-1:0]  col_count_ff, col_count_in;
   logic [LOAD_W-1:0] load_count_ff, load_count_in;
   logic              bank_ff, bank_in;
   logic [1:0]        jobs_ff, jobs_in;
   logic [DIM_W-1:0]  row_eff, col_eff;
   logic [2*DIM_W-1:0] total;
   logic [LOAD_W-1:0] count_next;
   logic              accept, complete;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = (jobs_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      row_eff    = sat_dim(row_count_ff);
      col_eff    = sat_dim(col_count_ff);
      total      = row_eff * col_eff;
      count_next = load_count_ff + LOAD_W'(1);
      complete   = ({1'b0, count_next} >= total);

      wr_en    = accept;
      wr_addr  = {bank_ff, load_count_ff[ADDR_W-1:0]};
      wr_data  = DATA_WIDTH'(req_element_value);
      push     = accept && complete;
      push_job = '{rows: row_eff, cols: col_eff, bank: bank_ff};

      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      load_count_in = load_count_ff;
      bank_in       = bank_ff;
      jobs_in       = jobs_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROW_COUNT: row_count_in = csr_wdata;
            REG_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         if (complete) begin
            load_count_in = '0;
            bank_in       = !bank_ff;
         end else begin
            load_count_in = count_next;
         end
      end

      if (push && !job_done) begin
         jobs_in = jobs_ff + 2'd1;
      end else if (!push && job_done) begin
         jobs_in = jobs_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= DIM_RESET;
         col_count_ff  <= DIM_RESET;
         load_count_ff <= '0;
         bank_ff       <= 1'b0;
         jobs_ff       <= '0;
      end else begin
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         load_count_ff <= load_count_in;
         bank_ff       <= bank_in;
         jobs_ff       <= jobs_in;
      end
   end

endmodule

/* hdl/soe_queue.sv */
// Two-entry job queue between the front end and the spiral sequencer.
// Holds matrix shape and bank per completed matrix; uses soe_pkg.
module soe_queue
   import soe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    q_valid,
   output job_type q_job
);

   job_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/soe_back.sv */
// Back end: two-bank element memory and the clockwise spiral walker.
// Takes jobs from soe_queue and drives the response channel; uses soe_pkg.
module soe_back
   import soe_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 8
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             wr_en,
   input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1):0] wr_addr,
   input  logic [DATA_WIDTH-1:0]                            wr_data,
   input  logic                                             q_valid,
   input  job_type                                          q_job,
   output logic                                             q_pop,
   output logic                                             job_done,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output logic [ELEM_W-1:0]                                rsp_spiral_value,
   output logic                                             rsp_is_last
);

   localparam int ADDR_W    = (MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;
   localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int PROD_W    = IDX_W + DIM_W;
   localparam int MEM_DEPTH = 2 << ADDR_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RIGHT,
      S_DOWN,
      S_LEFT,
      S_UP
   } state_type;

   logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  r_ff, r_in, c_ff, c_in;
   logic [IDX_W-1:0]  top_ff, top_in, bottom_ff, bottom_in;
   logic [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [LOAD_W-1:0] remaining_ff, remaining_in;
   logic [DIM_W-1:0]  cols_ff, cols_in;
   logic              bank_ff, bank_in;
   logic              valid_ff, valid_in;
   logic              last_ff, last_in;
   logic              issue, last;
   logic [PROD_W-1:0] elem_addr;
   logic [ADDR_W:0]   rd_addr;
   logic [2*DIM_W-1:0] job_total;

   assign issue    = (state_ff != S_IDLE) && (!valid_ff || !rsp_stall);
   assign last     = (remaining_ff == LOAD_W'(1));
   assign job_done = issue && last;
   assign elem_addr = PROD_W'(r_ff) * PROD_W'(cols_ff) + PROD_W'(c_ff);
   assign rd_addr  = {bank_ff, elem_addr[ADDR_W-1:0]};
   assign job_total = q_job.rows * q_job.cols;

   assign rsp_valid        = valid_ff;
   assign rsp_is_last      = last_ff;
   assign rsp_spiral_value = ELEM_W'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      remaining_in = remaining_ff;
      cols_in      = cols_ff;
      bank_in      = bank_ff;
      valid_in     = valid_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               state_in     = S_RIGHT;
               r_in         = '0;
               c_in         = '0;
               top_in       = '0;
               lo_in        = '0;
               bottom_in    = IDX_W'(q_job.rows - DIM_W'(1));
               hi_in        = IDX_W'(q_job.cols - DIM_W'(1));
               remaining_in = LOAD_W'(job_total);
               cols_in      = q_job.cols;
               bank_in      = q_job.bank;
            end
         end
         S_RIGHT: begin
            if (issue && !last) begin
               if (c_ff < hi_ff) begin
                  c_in = c_ff + IDX_W'(1);
               end else begin
                  top_in   = top_ff + IDX_W'(1);
                  r_in     = r_ff + IDX_W'(1);
                  state_in = S_DOWN;
               end
            end
         end
         S_DOWN: begin
            if (issue && !last) begin
               if (r_ff < bottom_ff) begin
                  r_in = r_ff + IDX_W'(1);
               end else begin
                  hi_in    = hi_ff - IDX_W'(1);
                  c_in     = c_ff - IDX_W'(1);
                  state_in = S_LEFT;
               end
            end
         end
         S_LEFT: begin
            if (issue && !last) begin
               if (c_ff > lo_ff) begin
                  c_in = c_ff - IDX_W'(1);
               end else begin
                  bottom_in = bottom_ff - IDX_W'(1);
                  r_in      = r_ff - IDX_W'(1);
                  state_in  = S_UP;
               end
            end
         end
         S_UP: begin
            if (issue && !last) begin
               if (r_ff > top_ff) begin
                  r_in = r_ff - IDX_W'(1);
               end else begin
                  lo_in    = lo_ff + IDX_W'(1);
                  c_in     = c_ff + IDX_W'(1);
                  state_in = S_RIGHT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (issue) begin
         remaining_in = remaining_ff - LOAD_W'(1);
         valid_in     = 1'b1;
         last_in      = last;
         if (last) begin
            state_in = S_IDLE;
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      r_ff         <= r_in;
      c_ff         <= c_in;
      top_ff       <= top_in;
      bottom_ff    <= bottom_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      remaining_ff <= remaining_in;
      cols_ff      <= cols_in;
      bank_ff      <= bank_in;
      last_ff      <= last_in;
   end

endmodule

/* hdl/spiral_order_emitter_top.sv */
// Top level of the spiral order emitter: front end, job queue and spiral back end.
// Depends on soe_pkg, soe_front, soe_queue and soe_back.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_stall    req_element_value
// rsp       out        rsp_valid/rsp_stall    rsp_spiral_value, rsp_is_last
// csr       in         csr_valid/csr_ready    csr_index, csr_wdata
//
// Each accepted request is written straight into the element memory; a finished matrix is
// emitted one element per cycle while rsp_stall is low, via the job queue and the read register.
// Two memory banks let the next matrix load while the previous one is emitted; req_stall
// rises only while both banks hold matrices that are not yet fully emitted.
// Reset clears the load, job and queue counters and sets both dimensions to 8; the element memory is not cleared.
module spiral_order_emitter_top
   import soe_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ELEM_W-1:0]    req_element_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ELEM_W-1:0]    rsp_spiral_value,
   output logic                 rsp_is_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int ADDR_W = (MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;

   logic                  wr_en;
   logic [ADDR_W:0]       wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  push, pop, q_valid, job_done;
   job_type               push_job, q_job;

   soe_front #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .push              (push),
      .push_job          (push_job),
      .job_done          (job_done)
   );

   soe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_job    (q_job)
   );

   soe_back #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .q_valid          (q_valid),
      .q_job            (q_job),
      .q_pop            (pop),
      .job_done         (job_done),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_spiral_value (rsp_spiral_value),
      .rsp_is_last      (rsp_is_last)
   );

endmodule
